/* src/i2cwo_pkg.sv */
// Shared types, operation codes and pin write tables for the write-only I2C pin sequencer.
`default_nettype none
package i2cwo_pkg;

	typedef enum logic [1:0] {
		OP_START_COMMAND = 2'd0,
		OP_START_DATA    = 2'd1,
		OP_DATA_BYTE     = 2'd2,
		OP_STOP          = 2'd3
	} op_t;

	localparam logic [7:0] CTRL_COMMAND = 8'h00;
	localparam logic [7:0] CTRL_DATA    = 8'h40;

	// One write to a single pin: either its output level or its drive enable.
	typedef struct packed {
		logic is_drive;
		logic pin_sda;
		logic value;
	} pin_wr_t;

	// Pin state as seen on the bus: levels and drive enables of both lines.
	typedef struct packed {
		logic sda_drive;
		logic scl_drive;
		logic sda_level;
		logic scl_level;
	} pin_state_t;

	// Start condition: take both pins, raise SCL and SDA, then pull SDA and SCL low.
	function automatic pin_wr_t start_write(input logic [2:0] step);
		pin_wr_t w;
		unique case (step)
			3'd0:    w = '{is_drive: 1'b1, pin_sda: 1'b1, value: 1'b1};
			3'd1:    w = '{is_drive: 1'b1, pin_sda: 1'b0, value: 1'b1};
			3'd2:    w = '{is_drive: 1'b0, pin_sda: 1'b0, value: 1'b1};
			3'd3:    w = '{is_drive: 1'b0, pin_sda: 1'b1, value: 1'b1};
			3'd4:    w = '{is_drive: 1'b0, pin_sda: 1'b1, value: 1'b0};
			default: w = '{is_drive: 1'b0, pin_sda: 1'b0, value: 1'b0};
		endcase
		return w;
	endfunction

	// Stop condition: both low, SCL then SDA high, then release SDA and SCL.
	function automatic pin_wr_t stop_write(input logic [2:0] step);
		pin_wr_t w;
		unique case (step)
			3'd0:    w = '{is_drive: 1'b0, pin_sda: 1'b0, value: 1'b0};
			3'd1:    w = '{is_drive: 1'b0, pin_sda: 1'b1, value: 1'b0};
			3'd2:    w = '{is_drive: 1'b0, pin_sda: 1'b0, value: 1'b1};
			3'd3:    w = '{is_drive: 1'b0, pin_sda: 1'b1, value: 1'b1};
			3'd4:    w = '{is_drive: 1'b1, pin_sda: 1'b1, value: 1'b0};
			default: w = '{is_drive: 1'b1, pin_sda: 1'b0, value: 1'b0};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

/* src/i2cwo_pins.sv */
// Pin write unit: applies one pin write per wr_en cycle to line levels and drive enables.
`default_nettype none
module i2cwo_pins (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire i2cwo_pkg::pin_wr_t   wr,
	output i2cwo_pkg::pin_state_t     state
);
	import i2cwo_pkg::*;

	pin_state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (wr_en) begin
			unique case ({wr.is_drive, wr.pin_sda})
				2'b00:   state_q.scl_level <= wr.value;
				2'b01:   state_q.sda_level <= wr.value;
				2'b10:   state_q.scl_drive <= wr.value;
				default: state_q.sda_drive <= wr.value;
			endcase
		end
	end

	assign state = state_q;

endmodule
`default_nettype wire

/* src/i2cwo_seq.sv */
// Operation sequencer: walks start, byte and stop phases and issues one pin write per step.
`default_nettype none
module i2cwo_seq (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire i2cwo_pkg::op_t     op,
	input  wire logic [7:0]         payload,
	input  wire logic [7:0]         addr,
	input  wire logic               advance,
	output logic                    busy,
	output i2cwo_pkg::pin_wr_t      wr,
	output logic                    wr_last
);
	import i2cwo_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_START,
		PH_BYTE,
		PH_STOP
	} phase_t;

	phase_t      phase_q;
	logic [2:0]  step_q;
	logic [2:0]  bit_q;
	logic [1:0]  sub_q;
	logic        ack_q;
	logic        more_q;
	logic [7:0]  shift_q;
	logic [7:0]  ctrl_q;

	assign busy = (phase_q != PH_IDLE);

	always_comb begin
		wr      = '{is_drive: 1'b0, pin_sda: 1'b0, value: 1'b0};
		wr_last = 1'b0;
		unique case (phase_q)
			PH_START: wr = start_write(step_q);
			PH_STOP: begin
				wr      = stop_write(step_q);
				wr_last = (step_q == 3'd5);
			end
			PH_BYTE: begin
				unique case (sub_q)
					2'd0:    wr = '{is_drive: 1'b0, pin_sda: 1'b1, value: ack_q | shift_q[7]};
					2'd1:    wr = '{is_drive: 1'b0, pin_sda: 1'b0, value: 1'b1};
					default: wr = '{is_drive: 1'b0, pin_sda: 1'b0, value: 1'b0};
				endcase
				wr_last = ack_q && (sub_q == 2'd2) && !more_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			step_q  <= '0;
			bit_q   <= '0;
			sub_q   <= '0;
			ack_q   <= 1'b0;
			more_q  <= 1'b0;
			shift_q <= '0;
			ctrl_q  <= '0;
		end else if (load) begin
			step_q <= '0;
			bit_q  <= '0;
			sub_q  <= '0;
			ack_q  <= 1'b0;
			ctrl_q <= (op == OP_START_DATA) ? CTRL_DATA : CTRL_COMMAND;
			unique case (op)
				OP_START_COMMAND, OP_START_DATA: begin
					phase_q <= PH_START;
					shift_q <= addr;
					more_q  <= 1'b1;
				end
				OP_DATA_BYTE: begin
					phase_q <= PH_BYTE;
					shift_q <= payload;
					more_q  <= 1'b0;
				end
				default: begin
					phase_q <= PH_STOP;
					more_q  <= 1'b0;
				end
			endcase
		end else if (advance) begin
			unique case (phase_q)
				PH_START: begin
					if (step_q == 3'd5) begin
						phase_q <= PH_BYTE;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				PH_STOP: begin
					if (step_q == 3'd5) begin
						phase_q <= PH_IDLE;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				PH_BYTE: begin
					if (sub_q == 2'd2) begin
						sub_q <= '0;
						if (ack_q) begin
							ack_q <= 1'b0;
							bit_q <= '0;
							if (more_q) begin
								shift_q <= ctrl_q;
								more_q  <= 1'b0;
							end else begin
								phase_q <= PH_IDLE;
							end
						end else begin
							shift_q <= {shift_q[6:0], 1'b0};
							bit_q   <= bit_q + 3'd1;
							if (bit_q == 3'd7) begin
								ack_q <= 1'b1;
							end
						end
					end else begin
						sub_q <= sub_q + 2'd1;
					end
				end
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

/* src/i2c_write_only_pin_sequencer_core.sv */
// Top level of the write-only I2C master that sequences raw pin writes.
// Each input beat is one bus operation: a start with the slave address and a command
// control byte, a start with the address and a data control byte, one data byte, or a
// stop. The block never samples an acknowledge. Every single write to a pin level or a
// pin direction comes out as one output beat that carries both line levels and both
// drive enables as they stand after that write, with tlast on the final beat of the
// operation. A start operation yields 60 beats, a data byte 27 and a stop 6; the
// sequencer issues at most one pin write per clock, so beats come out one per clock
// while the output side does not stall. While an operation is being sequenced,
// s_axis_tready is low; the next operation may be accepted while the last beat of the
// previous one still waits in the output register. The user writes the slave address
// byte through cfg_we and cfg_wdata only while idle; the block does not enforce this.
`default_nettype none
module i2c_write_only_pin_sequencer_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// Configuration: slave address byte, write bit included.
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	// Operation input.
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // [7:0] payload
	input  wire logic [1:0] s_axis_tuser,  // [1:0] op
	// Pin write results.
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,  // [0] scl_level, [1] sda_level, [2] scl_drive,
	                                       // [3] sda_drive, [7:4] zero
	output logic            m_axis_tlast
);
	import i2cwo_pkg::*;

	logic [7:0]  addr_q;
	logic        out_valid_q;
	logic        out_last_q;
	logic        load;
	logic        advance;
	logic        busy;
	logic        wr_last;
	pin_wr_t     wr;
	pin_state_t  pins;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= 8'h78;
		end else if (cfg_we) begin
			addr_q <= cfg_wdata;
		end
	end

	assign s_axis_tready = !busy;
	assign load          = s_axis_tvalid && s_axis_tready;

	// A pin write goes out whenever the output register is empty or being emptied.
	assign advance = busy && (!out_valid_q || m_axis_tready);

	i2cwo_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.op      (op_t'(s_axis_tuser)),
		.payload (s_axis_tdata),
		.addr    (addr_q),
		.advance (advance),
		.busy    (busy),
		.wr      (wr),
		.wr_last (wr_last)
	);

	// The pin state registers double as the output data register.
	i2cwo_pins u_pins (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (advance),
		.wr     (wr),
		.state  (pins)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
			out_last_q  <= wr_last;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {4'b0000, pins};

endmodule
`default_nettype wire
